// File: design/day_time_duration_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the day-time duration parser
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DAY_TIME_DURATION_PARSER_TOP_MACROS_SVH
`define DAY_TIME_DURATION_PARSER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DTDP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DTDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DTDP_ASSERT(lbl, prop, msg)
`define DTDP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/dtdp_pkg.sv
// ----------------------------------------------------------------------------
// dtdp_pkg
// Shared types, widths and codes of the day-time duration parser.
// ----------------------------------------------------------------------------
package dtdp_pkg;

    localparam int CHAR_W          = 8;
    localparam int STATUS_W        = 2;
    localparam int SECS_W          = 48;
    localparam int NANO_W          = 30;
    localparam int DIGIT_W         = 4;
    localparam int SECONDS_BITS_DEF = 48;
    localparam int FRAC_DIGITS_DEF = 9;
    localparam int QUEUE_DEPTH     = 4;
    localparam int PAD_IDX_W       = 4;
    localparam int CF_W            = 5;
    localparam int EF_W            = 2;

    localparam int MULT_W = 17;
    localparam logic [MULT_W-1:0] MULT_DAY  = 17'd86400;
    localparam logic [MULT_W-1:0] MULT_HOUR = 17'd3600;
    localparam logic [MULT_W-1:0] MULT_MIN  = 17'd60;
    localparam logic [MULT_W-1:0] MULT_SEC  = 17'd1;
    localparam logic [DIGIT_W-1:0] RADIX    = 4'd10;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
    localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // component flag bits
    localparam int CF_D = 0;
    localparam int CF_T = 1;
    localparam int CF_H = 2;
    localparam int CF_M = 3;
    localparam int CF_S = 4;

    // error flag bits
    localparam int EF_MAL = 0;
    localparam int EF_OVF = 1;

    // fraction padding to nanoseconds, indexed by digits kept
    localparam logic [NANO_W-1:0] PAD_SCALE [10] = '{
        30'd1000000000, 30'd100000000, 30'd10000000, 30'd1000000, 30'd100000,
        30'd10000, 30'd1000, 30'd100, 30'd10, 30'd1
    };

    typedef enum logic [3:0] {
        TK_DIGIT,
        TK_MINUS,
        TK_P,
        TK_D,
        TK_T,
        TK_H,
        TK_M,
        TK_S,
        TK_DOT,
        TK_OTHER
    } t_tok;

    typedef struct packed {
        t_tok               kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_tok_beat;

endpackage

// File: design/dtdp_if.sv
// ----------------------------------------------------------------------------
// dtdp_in_if / dtdp_out_if
// Valid/ready channels for text characters and parse results.
// ----------------------------------------------------------------------------
interface dtdp_in_if;
    logic                        valid;
    logic                        ready;
    logic [dtdp_pkg::CHAR_W-1:0] character;
    logic                        last_char;

    modport source (output valid, character, last_char, input ready);
    modport sink   (input valid, character, last_char, output ready);
endinterface

interface dtdp_out_if;
    logic                          valid;
    logic                          ready;
    logic [dtdp_pkg::STATUS_W-1:0] status;
    logic                          minus_flag;
    logic [dtdp_pkg::SECS_W-1:0]   whole_secs;
    logic [dtdp_pkg::NANO_W-1:0]   nano_part;

    modport source (output valid, status, minus_flag, whole_secs, nano_part,
                    input ready);
    modport sink   (input valid, status, minus_flag, whole_secs, nano_part,
                    output ready);
endinterface

// File: design/dtdp_front.sv
// ----------------------------------------------------------------------------
// dtdp_front
// Accepts character beats and classifies them into parser tokens.
// ----------------------------------------------------------------------------
module dtdp_front (
    dtdp_in_if.sink                i_in,
    input  logic                   i_q_full,
    output logic                   o_push,
    output dtdp_pkg::t_tok_beat    o_push_data
);

    dtdp_pkg::t_tok kind;

    always_comb begin
        case (i_in.character) inside
            [dtdp_pkg::CH_ZERO:dtdp_pkg::CH_NINE]: kind = dtdp_pkg::TK_DIGIT;
            dtdp_pkg::CH_MINUS: kind = dtdp_pkg::TK_MINUS;
            dtdp_pkg::CH_P:     kind = dtdp_pkg::TK_P;
            dtdp_pkg::CH_D:     kind = dtdp_pkg::TK_D;
            dtdp_pkg::CH_T:     kind = dtdp_pkg::TK_T;
            dtdp_pkg::CH_H:     kind = dtdp_pkg::TK_H;
            dtdp_pkg::CH_M:     kind = dtdp_pkg::TK_M;
            dtdp_pkg::CH_S:     kind = dtdp_pkg::TK_S;
            dtdp_pkg::CH_DOT:   kind = dtdp_pkg::TK_DOT;
            default:            kind = dtdp_pkg::TK_OTHER;
        endcase
    end

    assign i_in.ready        = !i_q_full;
    assign o_push            = i_in.valid && !i_q_full;
    assign o_push_data.kind  = kind;
    assign o_push_data.digit = dtdp_pkg::DIGIT_W'(i_in.character - dtdp_pkg::CH_ZERO);
    assign o_push_data.last  = i_in.last_char;

endmodule

// File: design/dtdp_queue.sv
// ----------------------------------------------------------------------------
// dtdp_queue
// Short token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
`include "day_time_duration_parser_top_macros.svh"

module dtdp_queue #(
    parameter int DEPTH = dtdp_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dtdp_pkg::t_tok_beat i_push_data,
    output logic                o_full,
    output logic                o_valid,
    output dtdp_pkg::t_tok_beat o_data,
    input  logic                i_pop
);

    localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);

    dtdp_pkg::t_tok_beat r_mem [DEPTH];
    logic [PTW-1:0]      r_wr_ptr;
    logic [PTW-1:0]      r_rd_ptr;
    logic [CW-1:0]       r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTW'(DEPTH - 1)) ? '0 : r_wr_ptr + PTW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTW'(DEPTH - 1)) ? '0 : r_rd_ptr + PTW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `DTDP_ASSERT(a_q_no_push_full, (i_push |-> !o_full), "push into full queue")
    `DTDP_ASSERT(a_q_no_pop_empty, (i_pop |-> o_valid), "pop from empty queue")
    `DTDP_ASSERT_NEXT(a_q_count_up, (i_push && !i_pop), (r_count == $past(r_count) + CW'(1)), "count lost a push")

endmodule

// File: design/dtdp_back.sv
// ----------------------------------------------------------------------------
// dtdp_back
// Duration grammar, seconds accumulation and result register.
// ----------------------------------------------------------------------------
`include "day_time_duration_parser_top_macros.svh"

module dtdp_back #(
    parameter int SECONDS_BITS = dtdp_pkg::SECONDS_BITS_DEF,
    parameter int FRAC_DIGITS  = dtdp_pkg::FRAC_DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  dtdp_pkg::t_tok_beat i_tok,
    output logic                o_pop,
    dtdp_out_if.source          o_out
);

    localparam int SB  = SECONDS_BITS;
    localparam int PW  = SB + dtdp_pkg::MULT_W + 1;
    localparam int FDW = $clog2(FRAC_DIGITS + 1);
    localparam int NW  = dtdp_pkg::NANO_W;
    localparam int SW  = dtdp_pkg::SECS_W;
    localparam int STW = dtdp_pkg::STATUS_W;
    localparam int IW  = dtdp_pkg::PAD_IDX_W;

    typedef enum logic [3:0] {
        PH_START,
        PH_SIGN,
        PH_AFTER_P,
        PH_DAY_NUM,
        PH_AFTER_D,
        PH_AFTER_T,
        PH_TIME_NUM,
        PH_AFTER_UNIT,
        PH_FRAC,
        PH_BAD
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic                          r_sign, n_sign;
    logic [SB-1:0]                 r_acc, n_acc;
    logic [SB-1:0]                 r_sum, n_sum;
    logic [NW-1:0]                 r_frac, n_frac;
    logic [FDW-1:0]                r_fdig, n_fdig;
    logic [dtdp_pkg::CF_W-1:0]     r_cflags, n_cflags;
    logic [dtdp_pkg::EF_W-1:0]     r_err, n_err;

    logic                          r_out_valid;
    logic [STW-1:0]                r_out_status;
    logic                          r_out_neg;
    logic [SW-1:0]                 r_out_secs;
    logic [NW-1:0]                 r_out_nano;

    logic [SB+3:0]                 acc10;
    logic                          acc_ovf;
    logic [dtdp_pkg::MULT_W-1:0]   mult;
    logic [PW-1:0]                 prod_sum;
    logic                          comp_ovf;
    logic [NW+3:0]                 frac10;
    logic [2*NW-1:0]               nano_full;
    logic                          do_take, do_add, do_bad;
    logic                          fin_mal, fin_ok;
    logic [STW-1:0]                fin_status;
    logic                          is_dig;

    assign o_pop  = i_q_valid && (!r_out_valid || o_out.ready);
    assign is_dig = (i_tok.kind == dtdp_pkg::TK_DIGIT);

    // digit step and unit scaling
    always_comb begin
        acc10   = (SB+4)'(r_acc) * (SB+4)'(dtdp_pkg::RADIX) + (SB+4)'(i_tok.digit);
        acc_ovf = |acc10[SB+3:SB];
        case (i_tok.kind)
            dtdp_pkg::TK_D: mult = dtdp_pkg::MULT_DAY;
            dtdp_pkg::TK_H: mult = dtdp_pkg::MULT_HOUR;
            dtdp_pkg::TK_M: mult = dtdp_pkg::MULT_MIN;
            default:        mult = dtdp_pkg::MULT_SEC;
        endcase
        prod_sum  = PW'(r_acc) * PW'(mult) + PW'(r_sum);
        comp_ovf  = |prod_sum[PW-1:SB];
        frac10    = (NW+4)'(r_frac) * (NW+4)'(dtdp_pkg::RADIX) + (NW+4)'(i_tok.digit);
        nano_full = (2*NW)'(r_frac) * (2*NW)'(dtdp_pkg::PAD_SCALE[IW'(r_fdig)]);
    end

    always_comb begin
        n_phase  = r_phase;
        n_sign   = r_sign;
        n_frac   = r_frac;
        n_fdig   = r_fdig;
        n_cflags = r_cflags;
        do_take  = 1'b0;
        do_add   = 1'b0;
        do_bad   = 1'b0;

        unique case (r_phase)
            PH_START: begin
                if (i_tok.kind == dtdp_pkg::TK_MINUS) begin
                    n_sign  = 1'b1;
                    n_phase = PH_SIGN;
                end else if (i_tok.kind == dtdp_pkg::TK_P) begin
                    n_phase = PH_AFTER_P;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_SIGN: begin
                if (i_tok.kind == dtdp_pkg::TK_P) begin
                    n_phase = PH_AFTER_P;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_AFTER_P: begin
                if (is_dig) begin
                    do_take = 1'b1;
                    n_phase = PH_DAY_NUM;
                end else if (i_tok.kind == dtdp_pkg::TK_T) begin
                    n_cflags[dtdp_pkg::CF_T] = 1'b1;
                    n_phase = PH_AFTER_T;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_DAY_NUM: begin
                if (is_dig) begin
                    do_take = 1'b1;
                end else if (i_tok.kind == dtdp_pkg::TK_D) begin
                    do_add = 1'b1;
                    n_cflags[dtdp_pkg::CF_D] = 1'b1;
                    n_phase = PH_AFTER_D;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_AFTER_D: begin
                if (i_tok.kind == dtdp_pkg::TK_T) begin
                    n_cflags[dtdp_pkg::CF_T] = 1'b1;
                    n_phase = PH_AFTER_T;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_AFTER_T: begin
                if (is_dig) begin
                    do_take = 1'b1;
                    n_phase = PH_TIME_NUM;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_TIME_NUM: begin
                if (is_dig) begin
                    do_take = 1'b1;
                end else if (i_tok.kind == dtdp_pkg::TK_H && !r_cflags[dtdp_pkg::CF_H]
                             && !r_cflags[dtdp_pkg::CF_M] && !r_cflags[dtdp_pkg::CF_S]) begin
                    do_add = 1'b1;
                    n_cflags[dtdp_pkg::CF_H] = 1'b1;
                    n_phase = PH_AFTER_UNIT;
                end else if (i_tok.kind == dtdp_pkg::TK_M && !r_cflags[dtdp_pkg::CF_M]
                             && !r_cflags[dtdp_pkg::CF_S]) begin
                    do_add = 1'b1;
                    n_cflags[dtdp_pkg::CF_M] = 1'b1;
                    n_phase = PH_AFTER_UNIT;
                end else if (i_tok.kind == dtdp_pkg::TK_S && !r_cflags[dtdp_pkg::CF_S]) begin
                    do_add = 1'b1;
                    n_cflags[dtdp_pkg::CF_S] = 1'b1;
                    n_phase = PH_AFTER_UNIT;
                end else if (i_tok.kind == dtdp_pkg::TK_DOT && !r_cflags[dtdp_pkg::CF_S]) begin
                    do_add  = 1'b1;
                    n_phase = PH_FRAC;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_AFTER_UNIT: begin
                if (is_dig && !r_cflags[dtdp_pkg::CF_S]) begin
                    do_take = 1'b1;
                    n_phase = PH_TIME_NUM;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_FRAC: begin
                if (is_dig) begin
                    // digits past the kept count are dropped
                    if (r_fdig < FDW'(FRAC_DIGITS)) begin
                        n_frac = frac10[NW-1:0];
                        n_fdig = r_fdig + FDW'(1);
                    end
                end else if (i_tok.kind == dtdp_pkg::TK_S) begin
                    n_cflags[dtdp_pkg::CF_S] = 1'b1;
                    n_phase = PH_AFTER_UNIT;
                end else begin
                    do_bad = 1'b1;
                end
            end
            PH_BAD: begin
                n_phase = PH_BAD;
            end
            default: begin
                n_phase = PH_BAD;
            end
        endcase

        n_acc = r_acc;
        n_sum = r_sum;
        n_err = r_err;
        if (do_take) begin
            if (acc_ovf) begin
                n_acc = '1;
                n_err[dtdp_pkg::EF_OVF] = 1'b1;
            end else begin
                n_acc = acc10[SB-1:0];
            end
        end
        if (do_add) begin
            n_acc = '0;
            if (comp_ovf) begin
                n_err[dtdp_pkg::EF_OVF] = 1'b1;
            end else begin
                n_sum = prod_sum[SB-1:0];
            end
        end
        if (do_bad) begin
            n_err[dtdp_pkg::EF_MAL] = 1'b1;
            n_phase = PH_BAD;
        end

        fin_mal = n_err[dtdp_pkg::EF_MAL]
                  || (n_phase != PH_AFTER_D && n_phase != PH_AFTER_UNIT);
        fin_ok  = !fin_mal && !n_err[dtdp_pkg::EF_OVF];
        if (fin_mal) begin
            fin_status = dtdp_pkg::ST_MALFORMED;
        end else if (n_err[dtdp_pkg::EF_OVF]) begin
            fin_status = dtdp_pkg::ST_OVERFLOW;
        end else begin
            fin_status = dtdp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_sign      <= 1'b0;
            r_acc       <= '0;
            r_sum       <= '0;
            r_frac      <= '0;
            r_fdig      <= '0;
            r_cflags    <= '0;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_tok.last) begin
                    r_phase      <= PH_START;
                    r_sign       <= 1'b0;
                    r_acc        <= '0;
                    r_sum        <= '0;
                    r_frac       <= '0;
                    r_fdig       <= '0;
                    r_cflags     <= '0;
                    r_err        <= '0;
                    r_out_valid  <= 1'b1;
                    r_out_status <= fin_status;
                    r_out_neg    <= fin_ok && r_sign && (n_sum != '0 || r_frac != '0);
                    r_out_secs   <= fin_ok ? SW'(n_sum) : '0;
                    r_out_nano   <= fin_ok ? nano_full[NW-1:0] : '0;
                end else begin
                    r_phase  <= n_phase;
                    r_sign   <= n_sign;
                    r_acc    <= n_acc;
                    r_sum    <= n_sum;
                    r_frac   <= n_frac;
                    r_fdig   <= n_fdig;
                    r_cflags <= n_cflags;
                    r_err    <= n_err;
                end
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.minus_flag  = r_out_neg;
    assign o_out.whole_secs  = r_out_secs;
    assign o_out.nano_part   = r_out_nano;

    `DTDP_ASSERT_NEXT(a_bk_clear_on_last, (o_pop && i_tok.last),
        (r_phase == PH_START && r_err == '0 && r_out_valid),
        "parser not cleared after last beat")
    `DTDP_ASSERT(a_bk_neg_nonzero, ((r_out_valid && r_out_neg) |->
        (r_out_status == dtdp_pkg::ST_OK && (r_out_secs != '0 || r_out_nano != '0))),
        "negative sign on zero or failed result")
    `DTDP_ASSERT(a_bk_fail_zero, ((r_out_valid && r_out_status != dtdp_pkg::ST_OK) |->
        (r_out_secs == '0 && r_out_nano == '0)), "failed result carries a value")

endmodule

// File: design/day_time_duration_parser_top.sv
// ----------------------------------------------------------------------------
// day_time_duration_parser_top
// Parses a day-time duration text (-P3DT4H5M6.25S form) one character a beat.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle whenever the token queue has room;
// characters flow through a classifier, a short queue and the grammar engine,
// and the result enters the output register when the beat marked last is
// popped. The grammar engine's path is set by the unit scaling of the
// digit accumulator (multiply by 86400/3600/60) plus the add into the running
// seconds total. A result is given only for the last character; it carries
// status (ok, malformed, seconds overflow), the sign, whole seconds and
// nanoseconds, and the parser is ready for the next text on the next beat.
// ----------------------------------------------------------------------------
module day_time_duration_parser_top #(
    parameter int SECONDS_BITS = dtdp_pkg::SECONDS_BITS_DEF,
    parameter int FRAC_DIGITS  = dtdp_pkg::FRAC_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtdp_in_if.sink    i_in,
    dtdp_out_if.source o_out
);

    logic                push;
    dtdp_pkg::t_tok_beat push_data;
    logic                q_full;
    logic                q_valid;
    dtdp_pkg::t_tok_beat q_data;
    logic                pop;

    dtdp_front u_front (
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    dtdp_queue #(
        .DEPTH (dtdp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (pop)
    );

    dtdp_back #(
        .SECONDS_BITS (SECONDS_BITS),
        .FRAC_DIGITS  (FRAC_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_tok     (q_data),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
